// ----- hw/rtl/nrgp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nrgp_pkg;

   // sweep and rotator sizing
   localparam int MAX_SAMPLES  = 4096;
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;

   localparam int CNT_W      = $clog2(MAX_SAMPLES + 1);
   localparam int POS_W      = $clog2(MAX_SAMPLES);
   localparam int STEP_W     = $clog2(CORDIC_STEPS);
   localparam int ATAN_IDX_W = $clog2(ATAN_ENTRIES);

   // field widths
   localparam int RANGE_W = 16;
   localparam int ANG_W   = 16;
   localparam int ASTEP_W = 12;
   localparam int INDEX_W = 12;
   localparam int GOAL_W  = 17;
   localparam int DIST_W  = 17;

   // rotator datapath widths: x/y in Q30, z in 2^-32 turn
   localparam int CW     = 34;
   localparam int ZW     = 33;
   localparam int PROD_W = DIST_W + CW;

   localparam logic [CW-1:0] CORDIC_ONE_K = CW'(652032874);
   localparam int RND_SHIFT = 30;
   localparam int MAG_MAX   = 65535;

   // CSR map
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;
   localparam logic [1:0] REG_START_ANGLE = 2'd0;
   localparam logic [1:0] REG_ANGLE_STEP  = 2'd1;
   localparam logic [1:0] REG_MAX_RANGE   = 2'd2;
   localparam logic [1:0] REG_STANDOFF    = 2'd3;

   typedef enum logic [2:0] {
      ST_SCAN,
      ST_ANGLE,
      ST_ROTATE,
      ST_MULX,
      ST_MULY,
      ST_RNDY,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic angle_load;
      logic rot_step;
      logic mul_x;
      logic mul_y;
      logic rnd_y;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic rot_last;
      logic out_free;
   } status_type;

   function automatic logic [31:0] atan_turn32(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:    v = 32'h20000000;
         5'd1:    v = 32'h12E4051E;
         5'd2:    v = 32'h09FB385B;
         5'd3:    v = 32'h051111D4;
         5'd4:    v = 32'h028B0D43;
         5'd5:    v = 32'h0145D7E1;
         5'd6:    v = 32'h00A2F61E;
         5'd7:    v = 32'h00517C55;
         5'd8:    v = 32'h0028BE53;
         5'd9:    v = 32'h00145F2F;
         5'd10:   v = 32'h000A2F98;
         5'd11:   v = 32'h000517CC;
         5'd12:   v = 32'h00028BE6;
         5'd13:   v = 32'h000145F3;
         5'd14:   v = 32'h0000A2FA;
         5'd15:   v = 32'h0000517D;
         5'd16:   v = 32'h000028BE;
         5'd17:   v = 32'h0000145F;
         5'd18:   v = 32'h00000A30;
         5'd19:   v = 32'h00000518;
         5'd20:   v = 32'h0000028C;
         5'd21:   v = 32'h00000146;
         5'd22:   v = 32'h000000A3;
         5'd23:   v = 32'h00000051;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/nrgp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nrgp_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_last_sample,
   output logic                    req_stall,
   input  wire nrgp_pkg::status_type sts,
   output nrgp_pkg::cmd_type       cmd
);
   import nrgp_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SCAN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_SCAN: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && req_last_sample) begin
               state_in = ST_ANGLE;
            end
         end
         ST_ANGLE: begin
            cmd.angle_load = 1'b1;
            state_in       = ST_ROTATE;
         end
         ST_ROTATE: begin
            cmd.rot_step = 1'b1;
            if (sts.rot_last) begin
               state_in = ST_MULX;
            end
         end
         ST_MULX: begin
            cmd.mul_x = 1'b1;
            state_in  = ST_MULY;
         end
         ST_MULY: begin
            cmd.mul_y = 1'b1;
            state_in  = ST_RNDY;
         end
         ST_RNDY: begin
            cmd.rnd_y = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            // previous word may still sit in the output register
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_SCAN;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_rot_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROTATE && sts.rot_last) |=> (state_ff == ST_MULX))
      else $error("rotator did not hand over to scaling");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result loaded over an untaken word");

   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_last_sample) |=> (state_ff == ST_ANGLE))
      else $error("last sample did not start the goal computation");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/nrgp_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nrgp_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire nrgp_pkg::cmd_type                 cmd,
   output nrgp_pkg::status_type                   sts,
   input  wire logic [nrgp_pkg::ANG_W-1:0]        start_angle,
   input  wire logic [nrgp_pkg::ASTEP_W-1:0]      angle_step,
   input  wire logic [nrgp_pkg::RANGE_W-1:0]      max_range,
   input  wire logic [nrgp_pkg::RANGE_W-1:0]      standoff,
   input  wire logic [nrgp_pkg::RANGE_W-1:0]      req_range_mm,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_found,
   output logic signed [nrgp_pkg::GOAL_W-1:0]     rsp_goal_x,
   output logic signed [nrgp_pkg::GOAL_W-1:0]     rsp_goal_y,
   output logic [nrgp_pkg::RANGE_W-1:0]           rsp_nearest_range,
   output logic [nrgp_pkg::INDEX_W-1:0]           rsp_nearest_index
);
   import nrgp_pkg::*;

   function automatic logic [GOAL_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
      logic              neg;
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] q;
      logic [15:0]       m16;
      neg = p[PROD_W-1];
      mag = neg ? PROD_W'(-p) : PROD_W'(p);
      q   = (mag + (PROD_W'(1) << (RND_SHIFT - 1))) >> RND_SHIFT;
      m16 = (q > PROD_W'(MAG_MAX)) ? 16'(MAG_MAX) : q[15:0];
      return neg ? (GOAL_W'(0) - {1'b0, m16}) : {1'b0, m16};
   endfunction

   // sweep state
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               have_hit_ff, have_hit_in;
   logic [RANGE_W-1:0] best_range_ff, best_range_in;
   logic [POS_W-1:0]   best_pos_ff, best_pos_in;

   // rotator
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [1:0]           quad_ff, quad_in;
   logic [STEP_W-1:0]    i_ff, i_in;

   // scaling
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [GOAL_W-1:0]        gx_ff, gx_in, gy_ff, gy_in;

   // output word
   logic                     out_valid_ff, out_valid_in;
   logic                     found_ff, found_in;
   logic signed [GOAL_W-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [RANGE_W-1:0]       orange_ff, orange_in;
   logic [INDEX_W-1:0]       oindex_ff, oindex_in;

   logic                     qualify;
   logic [POS_W+ASTEP_W-1:0] pos_step;
   logic [ANG_W-1:0]         ang;
   logic [ANG_W-1:0]         ang_off;
   logic [ANG_W-1:0]         resid;
   logic signed [CW-1:0]     xs, ys, cos_v, sin_v, fsel;
   logic signed [ZW-1:0]     atan_v;
   logic signed [DIST_W-1:0] span;

   assign qualify = (req_range_mm != '0) && (req_range_mm < max_range)
                    && (!have_hit_ff || (req_range_mm < best_range_ff));

   assign pos_step = best_pos_ff * angle_step;
   assign ang      = start_angle + ANG_W'(pos_step);
   assign ang_off  = ang + ANG_W'(16'h2000);
   assign resid    = ang - {ang_off[ANG_W-1:ANG_W-2], {(ANG_W-2){1'b0}}};

   assign xs     = x_ff >>> i_ff;
   assign ys     = y_ff >>> i_ff;
   assign atan_v = ZW'(atan_turn32(ATAN_IDX_W'(i_ff)));

   always_comb begin
      case (quad_ff)
         2'd0: begin cos_v = x_ff;  sin_v = y_ff;  end
         2'd1: begin cos_v = -y_ff; sin_v = x_ff;  end
         2'd2: begin cos_v = -x_ff; sin_v = -y_ff; end
         default: begin cos_v = y_ff; sin_v = -x_ff; end
      endcase
   end

   assign span = $signed({1'b0, best_range_ff}) - $signed({1'b0, standoff});
   assign fsel = cmd.mul_x ? cos_v : sin_v;

   always_comb begin
      count_in      = count_ff;
      have_hit_in   = have_hit_ff;
      best_range_in = best_range_ff;
      best_pos_in   = best_pos_ff;
      if (cmd.accept && (count_ff < CNT_W'(MAX_SAMPLES))) begin
         count_in = count_ff + CNT_W'(1);
         if (qualify) begin
            best_range_in = req_range_mm;
            best_pos_in   = POS_W'(count_ff);
            have_hit_in   = 1'b1;
         end
      end
      if (cmd.emit) begin
         count_in      = '0;
         have_hit_in   = 1'b0;
         best_range_in = max_range;
         best_pos_in   = '0;
      end
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      quad_in = quad_ff;
      i_in    = i_ff;
      if (cmd.angle_load) begin
         x_in    = CORDIC_ONE_K;
         y_in    = '0;
         z_in    = ZW'($signed({resid, 16'h0000}));
         quad_in = ang_off[ANG_W-1:ANG_W-2];
         i_in    = '0;
      end else if (cmd.rot_step) begin
         if (!z_ff[ZW-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_v;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_v;
         end
         i_in = i_ff + STEP_W'(1);
      end
   end

   always_comb begin
      prod_in = prod_ff;
      gx_in   = gx_ff;
      gy_in   = gy_ff;
      if (cmd.mul_x || cmd.mul_y) begin
         prod_in = span * fsel;
      end
      if (cmd.mul_y) begin
         gx_in = round_sat(prod_ff);
      end
      if (cmd.rnd_y) begin
         gy_in = round_sat(prod_ff);
      end
   end

   assign sts.rot_last = (i_ff == STEP_W'(CORDIC_STEPS - 1));
   assign sts.out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in = out_valid_ff;
      found_in     = found_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      orange_in    = orange_ff;
      oindex_in    = oindex_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         found_in     = have_hit_ff;
         ox_in        = have_hit_ff ? $signed(gx_ff) : '0;
         oy_in        = have_hit_ff ? $signed(gy_ff) : '0;
         orange_in    = have_hit_ff ? best_range_ff : '0;
         oindex_in    = have_hit_ff ? INDEX_W'(best_pos_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         have_hit_ff   <= 1'b0;
         best_range_ff <= max_range;
         best_pos_ff   <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         have_hit_ff   <= have_hit_in;
         best_range_ff <= best_range_in;
         best_pos_ff   <= best_pos_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      quad_ff       <= quad_in;
      i_ff          <= i_in;
      prod_ff       <= prod_in;
      gx_ff         <= gx_in;
      gy_ff         <= gy_in;
      found_ff      <= found_in;
      ox_ff         <= ox_in;
      oy_ff         <= oy_in;
      orange_ff     <= orange_in;
      oindex_ff     <= oindex_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_goal_x        = ox_ff;
   assign rsp_goal_y        = oy_ff;
   assign rsp_nearest_range = orange_ff;
   assign rsp_nearest_index = oindex_ff;

`ifndef SYNTHESIS
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count ran past the sweep limit");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !found_ff) |-> (ox_ff == '0 && oy_ff == '0
                                       && orange_ff == '0 && oindex_ff == '0))
      else $error("empty sweep word carries nonzero fields");

   a_sweep_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (!have_hit_ff && count_ff == '0 && out_valid_ff))
      else $error("sweep state not cleared on result load");

   a_hit_nonzero: assert property (@(posedge clock) disable iff (reset)
      have_hit_ff |-> (best_range_ff != '0))
      else $error("zero range held as nearest return");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/nearest_return_goal_point_top.sv -----
// channel   direction  handshake             word
// req       in         req_valid/req_stall   range_mm, last_sample
// rsp       out        rsp_valid/rsp_stall   found, goal_x, goal_y, nearest_range, nearest_index
// csr       in/out     psel/penable/pready   4 x 32-bit registers at byte address 4*i
//
// A sample is taken every cycle while a sweep is being scanned.
// After the last sample req_stall stays high through the angle load, one CORDIC step per cycle,
// two scale multiplies (the x result rounds during the second), the y round and the load.
// The load waits further while an earlier word sits stalled in the output register.
// reset is synchronous and clears the sweep, the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module nearest_return_goal_point_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [nrgp_pkg::RANGE_W-1:0]      req_range_mm,
   input  wire logic                              req_last_sample,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_found,
   output logic signed [nrgp_pkg::GOAL_W-1:0]     rsp_goal_x,
   output logic signed [nrgp_pkg::GOAL_W-1:0]     rsp_goal_y,
   output logic [nrgp_pkg::RANGE_W-1:0]           rsp_nearest_range,
   output logic [nrgp_pkg::INDEX_W-1:0]           rsp_nearest_index,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [nrgp_pkg::CSR_AW-1:0]       paddr,
   input  wire logic [nrgp_pkg::CSR_DW-1:0]       pwdata,
   output logic [nrgp_pkg::CSR_DW-1:0]            prdata,
   output logic                                   pready
);
   import nrgp_pkg::*;

   logic [ANG_W-1:0]   start_angle_ff, start_angle_in;
   logic [ASTEP_W-1:0] angle_step_ff, angle_step_in;
   logic [RANGE_W-1:0] max_range_ff, max_range_in;
   logic [RANGE_W-1:0] standoff_ff, standoff_in;
   logic               csr_wr;
   logic [1:0]         reg_sel;
   cmd_type            cmd;
   status_type         sts;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign reg_sel = paddr[3:2];

   always_comb begin
      start_angle_in = start_angle_ff;
      angle_step_in  = angle_step_ff;
      max_range_in   = max_range_ff;
      standoff_in    = standoff_ff;
      if (csr_wr) begin
         case (reg_sel)
            REG_START_ANGLE: start_angle_in = pwdata[ANG_W-1:0];
            REG_ANGLE_STEP:  angle_step_in  = pwdata[ASTEP_W-1:0];
            REG_MAX_RANGE:   max_range_in   = pwdata[RANGE_W-1:0];
            REG_STANDOFF:    standoff_in    = pwdata[RANGE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_START_ANGLE: prdata = CSR_DW'(start_angle_ff);
         REG_ANGLE_STEP:  prdata = CSR_DW'(angle_step_ff);
         REG_MAX_RANGE:   prdata = CSR_DW'(max_range_ff);
         REG_STANDOFF:    prdata = CSR_DW'(standoff_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff <= 16'h8000;
         angle_step_ff  <= 12'd182;
         max_range_ff   <= 16'hFFFF;
         standoff_ff    <= 16'd300;
      end else begin
         start_angle_ff <= start_angle_in;
         angle_step_ff  <= angle_step_in;
         max_range_ff   <= max_range_in;
         standoff_ff    <= standoff_in;
      end
   end

   nrgp_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_sample (req_last_sample),
      .req_stall       (req_stall),
      .sts             (sts),
      .cmd             (cmd)
   );

   nrgp_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .start_angle       (start_angle_ff),
      .angle_step        (angle_step_ff),
      .max_range         (max_range_ff),
      .standoff          (standoff_ff),
      .req_range_mm      (req_range_mm),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_goal_x        (rsp_goal_x),
      .rsp_goal_y        (rsp_goal_y),
      .rsp_nearest_range (rsp_nearest_range),
      .rsp_nearest_index (rsp_nearest_index)
   );

endmodule

`default_nettype wire
